// ===== design/mcpg_pkg.sv =====
// mcpg_pkg: shared constants and types for the midpoint circle point generator
// no dependencies; imported by every module of the block
`default_nettype none
package mcpg_pkg;

  // default octant coordinate width
  localparam int COORD_BITS_DEF = 10;
  // radius after reset
  localparam int RADIUS_RESET   = 10;
  // depth of the job queue between front and back, a power of two
  localparam int QUEUE_DEPTH    = 4;
  // points emitted per octant step
  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_IDX_BITS  = $clog2(POINTS_PER_STEP);
  localparam logic [POINT_IDX_BITS-1:0] LAST_POINT = POINT_IDX_BITS'(POINTS_PER_STEP - 1);

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== design/mcpg_front.sv =====
// mcpg_front: takes restart and advance items, holds x, y and decision, runs octant steps
// depends on mcpg_pkg; pushes one job per emitting step into mcpg_queue
`default_nettype none
module mcpg_front #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    restart,
  input  wire logic [COORD_BITS-1:0]   radius_reg,
  input  wire mcpg_pkg::q_stat_t       q_stat,
  output logic                         push,
  output logic [2*COORD_BITS:0]        push_data
);
  import mcpg_pkg::*;

  localparam int DecBits = COORD_BITS + 3;

  logic [COORD_BITS-1:0] octant_x, octant_y;
  logic [DecBits-1:0]    decision;
  logic                  running;

  logic                  accept;
  logic                  d_pos;
  logic [DecBits-1:0]    decision_next;
  logic [COORD_BITS:0]   nx;
  logic signed [COORD_BITS+1:0] nx_s, ny_s;
  logic                  done;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // decision > 0
  assign d_pos = !decision[DecBits-1] && (decision != '0);

  always_comb begin
    if (d_pos) begin
      decision_next = decision + DecBits'({octant_x, 2'b00}) - DecBits'({octant_y, 2'b00})
                      + DecBits'(10);
    end else begin
      decision_next = decision + DecBits'({octant_x, 2'b00}) + DecBits'(6);
    end
  end

  assign nx   = {1'b0, octant_x} + (COORD_BITS+1)'(1);
  assign nx_s = signed'({1'b0, nx});
  assign ny_s = signed'({2'b00, octant_y}) - (COORD_BITS+2)'(d_pos);
  assign done = nx_s > ny_s;

  assign push      = accept && !restart && running;
  assign push_data = {done, octant_x, octant_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      octant_x <= '0;
      octant_y <= '0;
      decision <= '0;
      running  <= 1'b0;
    end else if (accept && restart) begin
      octant_x <= '0;
      octant_y <= radius_reg;
      decision <= DecBits'(3) - DecBits'({radius_reg, 1'b0});
      running  <= 1'b1;
    end else if (push) begin
      octant_x <= nx[COORD_BITS-1:0];
      octant_y <= ny_s[COORD_BITS-1:0];
      decision <= decision_next;
      running  <= !done;
    end
  end

endmodule
`default_nettype wire

// ===== design/mcpg_queue.sv =====
// mcpg_queue: short register queue of pending octant jobs
// depends on mcpg_pkg for the status struct
`default_nettype none
module mcpg_queue #(
  parameter int WIDTH = 21,
  parameter int DEPTH = mcpg_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output mcpg_pkg::q_stat_t     q_stat
);
  import mcpg_pkg::*;

  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [AddrBits-1:0] wr_ptr, rd_ptr;
  logic [AddrBits:0]   count;

  assign q_stat.full  = (count == (AddrBits+1)'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrBits'(DEPTH-1)) ? '0 : wr_ptr + AddrBits'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrBits'(DEPTH-1)) ? '0 : rd_ptr + AddrBits'(1);
      end
      count <= count + (AddrBits+1)'(push) - (AddrBits+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/mcpg_back.sv =====
// mcpg_back: walks the eight mirrored points of the job at the queue head
// depends on mcpg_pkg; pops mcpg_queue after the eighth transfer
`default_nettype none
module mcpg_back #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mcpg_pkg::q_stat_t           q_stat,
  input  wire logic [2*COORD_BITS:0]       head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [COORD_BITS:0]       point_x,
  output logic signed [COORD_BITS:0]       point_y,
  output logic                             last_in_step,
  output logic                             circle_done
);
  import mcpg_pkg::*;

  logic [POINT_IDX_BITS-1:0] idx;
  logic [COORD_BITS-1:0]     hx, hy;
  logic signed [COORD_BITS:0] base_x, base_y;
  logic                      xfer;

  assign hx = head[2*COORD_BITS-1:COORD_BITS];
  assign hy = head[COORD_BITS-1:0];

  assign out_valid = !q_stat.empty;
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && (idx == LAST_POINT);

  // second half of the run swaps x and y; bit 0 negates x, bit 1 negates y
  assign base_x = signed'({1'b0, idx[2] ? hy : hx});
  assign base_y = signed'({1'b0, idx[2] ? hx : hy});
  assign point_x      = idx[0] ? -base_x : base_x;
  assign point_y      = idx[1] ? -base_y : base_y;
  assign last_in_step = (idx == LAST_POINT);
  assign circle_done  = head[2*COORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= idx + POINT_IDX_BITS'(1);
    end
  end

endmodule
`default_nettype wire

// ===== design/midpoint_circle_point_generator.sv =====
// midpoint_circle_point_generator: top level of the midpoint circle point generator
// depends on mcpg_pkg, mcpg_front, mcpg_queue and mcpg_back
// a transferred advance item of a running circle is registered in the job queue; its points come from the queue head
// throughput: one point per cycle on the single result channel while a job waits and out_stall is low
// restart items emit nothing; items are taken while points drain
// up to four steps may wait in the job queue; input stalls only when it is full
// reset (rst, synchronous): circle idle, queue empty, radius back to 10
`default_nettype none
module midpoint_circle_point_generator #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // radius register write
  input  wire logic                    radius_valid,
  output logic                         radius_ready,
  input  wire logic [COORD_BITS-1:0]   radius,
  // item input
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    restart,
  // point output
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         last_in_step,
  output logic                         circle_done
);
  import mcpg_pkg::*;

  localparam int JobBits = 2*COORD_BITS + 1;

  logic [COORD_BITS-1:0] radius_reg;
  q_stat_t               q_stat;
  logic                  push, pop;
  logic [JobBits-1:0]    push_data, head;

  // radius register, always ready for a transfer
  assign radius_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_reg <= COORD_BITS'(RADIUS_RESET);
    end else if (radius_valid && radius_ready) begin
      radius_reg <= radius;
    end
  end

  // front: classifies restart and advance, steps the octant point
  mcpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .restart    (restart),
    .radius_reg (radius_reg),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  // job queue: done flag, x and y of each emitting step
  mcpg_queue #(.WIDTH(JobBits), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: eight mirrored points per job
  mcpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_in_step (last_in_step),
    .circle_done  (circle_done)
  );

endmodule
`default_nettype wire

// ===== design/mcpg_checker.sv =====
// mcpg_checker: port-level assertions for the midpoint circle point generator
// depends on mcpg_pkg; bound to midpoint_circle_point_generator below
`default_nettype none
module mcpg_checker #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  radius_valid,
  input wire logic                  radius_ready,
  input wire logic [COORD_BITS-1:0] radius,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  restart,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS:0]   point_x,
  input wire logic [COORD_BITS:0]   point_y,
  input wire logic                  last_in_step,
  input wire logic                  circle_done
);
  import mcpg_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && !out_stall;

  // nothing pending straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y))
    else $error("stalled point changed");

  // a run of eight points is never broken
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !last_in_step |=> out_valid)
    else $error("point run broken");

  // end flag is the same on all points of one step
  a_done_const: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !last_in_step |=> circle_done == $past(circle_done))
    else $error("circle_done changed within a step");

endmodule

bind midpoint_circle_point_generator mcpg_checker #(.COORD_BITS(COORD_BITS)) u_mcpg_checker (.*);
`default_nettype wire
